// File: hdl/rcp_pkg.sv
// ----------------------------------------------------------------------------
// Resource container parser package
// Shared constants, payload structs and event type for the parser block.
// ----------------------------------------------------------------------------
package rcp_pkg;

  // Entry table limits
  localparam int unsigned MaxEntries = 64;
  localparam int unsigned EntryCntW  = $clog2(MaxEntries + 2);
  localparam logic [EntryCntW-1:0] EntryMax = EntryCntW'(MaxEntries);

  // Header layout
  localparam int unsigned HeaderLen = 16;
  localparam logic [3:0] TypeEndPos = 4'd4;
  localparam logic [3:0] NameEndPos = 4'd12;
  localparam logic [3:0] LastPos    = 4'd15;

  // Byte counter, saturating one past the 24-bit offset range
  localparam int unsigned ByteCntW = 25;
  localparam logic [ByteCntW-1:0] ByteCap  = 25'h1000000;
  localparam logic [ByteCntW-1:0] MinFile  = ByteCntW'(HeaderLen);
  localparam logic [23:0]         OffsetMax = 24'hFFFFFF;

  // Config register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgMaxFileSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFindType    = 2'd1;

  // Status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadSize   = 3'd1;
  localparam logic [2:0] StTruncHdr  = 3'd2;
  localparam logic [2:0] StTruncBody = 3'd3;
  localparam logic [2:0] StTooMany   = 3'd4;

  // Record kinds
  localparam logic KindEntry  = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Queue depth between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } rcp_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [5:0]  entry_index;
    logic [31:0] entry_type;
    logic [63:0] entry_name;
    logic [31:0] payload_len;
    logic [23:0] data_offset;
    logic [2:0]  status_code;
    logic [6:0]  entry_total;
    logic        match_found;
    logic [5:0]  match_index;
    logic        last_result;
  } rcp_out_t;

  // What one byte produced: an entry record, a status record, or both
  typedef struct packed {
    logic     has_entry;
    logic     has_status;
    rcp_out_t entry_rec;
    rcp_out_t status_rec;
  } rcp_event_t;

endpackage

// File: hdl/resource_container_parser_unit.sv
// ----------------------------------------------------------------------------
// Resource container parser unit
// Streams a container file byte by byte, emits one record per entry header
// (up to 64) and a final status record on the end-of-file byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid_i/in_ready_o | in_data_i  (rcp_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (rcp_out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte is taken per cycle; the front end updates the walk state in the
// cycle of the transfer. A byte that closes a header and ends the file gives
// two results, which the back end sends in turn. A 4-deep event queue
// lets input continue while results wait; input stalls only when it is full.
// Reset clears the walk state and loads the config defaults; no clearing pass.
// ----------------------------------------------------------------------------
module resource_container_parser_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rcp_pkg::rcp_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rcp_pkg::rcp_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);

  logic                push;
  rcp_pkg::rcp_event_t push_event;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  rcp_pkg::rcp_event_t q_head;

  // Byte walk and record building
  rcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .event_o     (push_event)
  );

  // Decoupling queue
  rcp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_event),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Result sequencing
  rcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hdl/rcp_front.sv
// ----------------------------------------------------------------------------
// Resource container parser front end
// Walks the byte stream, holds config, and emits record events per byte.
// ----------------------------------------------------------------------------
module rcp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rcp_pkg::rcp_in_t            in_data_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output rcp_pkg::rcp_event_t         event_o
);

  logic [23:0] max_size_q;
  logic [31:0] find_type_q;

  logic        in_payload_q, in_payload_d;
  logic [3:0]  header_pos_q, header_pos_d;
  logic [31:0] type_shift_q, type_shift_d;
  logic [63:0] name_shift_q, name_shift_d;
  logic [31:0] size_shift_q, size_shift_d;
  logic [31:0] payload_left_q, payload_left_d;
  logic [rcp_pkg::ByteCntW-1:0]  byte_total_q, byte_total_d;
  logic [rcp_pkg::EntryCntW-1:0] entries_seen_q, entries_seen_d;
  logic [2:0]  walk_error_q, walk_error_d;
  logic [1:0]  match_count_q, match_count_d;
  logic [5:0]  first_match_q, first_match_d;

  logic        accept;
  logic        entry_done;
  logic [2:0]  code;

  assign in_ready_o  = !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q  <= 24'hFFFFFF;
      find_type_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcp_pkg::CfgMaxFileSize: max_size_q  <= cfg_data_i[23:0];
        rcp_pkg::CfgFindType:    find_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Walk update and record building
  always_comb begin
    in_payload_d   = in_payload_q;
    header_pos_d   = header_pos_q;
    type_shift_d   = type_shift_q;
    name_shift_d   = name_shift_q;
    size_shift_d   = size_shift_q;
    payload_left_d = payload_left_q;
    byte_total_d   = byte_total_q;
    entries_seen_d = entries_seen_q;
    walk_error_d   = walk_error_q;
    match_count_d  = match_count_q;
    first_match_d  = first_match_q;
    entry_done     = 1'b0;
    code           = rcp_pkg::StOk;
    push_o         = 1'b0;
    event_o        = '0;

    if (accept) begin
      if (byte_total_q < rcp_pkg::ByteCap) begin
        byte_total_d = byte_total_q + 1'b1;
      end

      if (in_payload_q) begin
        // payload byte: count down
        payload_left_d = payload_left_q - 32'd1;
        if (payload_left_d == '0) begin
          in_payload_d = 1'b0;
          entry_done   = 1'b1;
        end
      end else begin
        // header byte: shift into the field it belongs to
        if (header_pos_q < rcp_pkg::TypeEndPos) begin
          type_shift_d = {in_data_i.data_byte, type_shift_q[31:8]};
        end else if (header_pos_q < rcp_pkg::NameEndPos) begin
          name_shift_d = {in_data_i.data_byte, name_shift_q[63:8]};
        end else begin
          size_shift_d = {in_data_i.data_byte, size_shift_q[31:8]};
        end
        header_pos_d = header_pos_q + 4'd1;

        if (header_pos_q == rcp_pkg::LastPos) begin
          if (entries_seen_q < rcp_pkg::EntryMax) begin
            event_o.has_entry             = 1'b1;
            event_o.entry_rec.record_kind = rcp_pkg::KindEntry;
            event_o.entry_rec.entry_index = entries_seen_q[5:0];
            event_o.entry_rec.entry_type  = type_shift_q;
            event_o.entry_rec.entry_name  = name_shift_q;
            event_o.entry_rec.payload_len = size_shift_d;
            event_o.entry_rec.data_offset = byte_total_d[24] ? rcp_pkg::OffsetMax
                                                              : byte_total_d[23:0];
            if (type_shift_q == find_type_q) begin
              if (match_count_q == 2'd0) begin
                first_match_d = entries_seen_q[5:0];
              end
              if (match_count_q < 2'd2) begin
                match_count_d = match_count_q + 2'd1;
              end
            end
          end
          if (entries_seen_q <= rcp_pkg::EntryMax) begin
            entries_seen_d = entries_seen_q + 1'b1;
          end
          payload_left_d = size_shift_d;
          if (size_shift_d != '0) begin
            in_payload_d = 1'b1;
          end else begin
            entry_done = 1'b1;
          end
        end
      end

      // latch the too-many error once an entry past the limit completes
      if (entry_done && entries_seen_d > rcp_pkg::EntryMax &&
          walk_error_q == rcp_pkg::StOk) begin
        walk_error_d = rcp_pkg::StTooMany;
      end

      if (in_data_i.end_of_file) begin
        // final status, in priority order
        if (byte_total_d < rcp_pkg::MinFile ||
            byte_total_d > {1'b0, max_size_q}) begin
          code = rcp_pkg::StBadSize;
        end else if (walk_error_d != rcp_pkg::StOk) begin
          code = walk_error_d;
        end else if (!in_payload_d && header_pos_d != 4'd0) begin
          code = rcp_pkg::StTruncHdr;
        end else if (in_payload_d) begin
          code = rcp_pkg::StTruncBody;
        end else begin
          code = rcp_pkg::StOk;
        end
        event_o.has_status             = 1'b1;
        event_o.status_rec.record_kind = rcp_pkg::KindStatus;
        event_o.status_rec.status_code = code;
        if (code == rcp_pkg::StOk) begin
          event_o.status_rec.entry_total = 7'(entries_seen_d);
          if (match_count_d == 2'd1) begin
            event_o.status_rec.match_found = 1'b1;
            event_o.status_rec.match_index = first_match_d;
          end
        end

        // next byte starts a new file
        in_payload_d   = 1'b0;
        header_pos_d   = '0;
        type_shift_d   = '0;
        name_shift_d   = '0;
        size_shift_d   = '0;
        payload_left_d = '0;
        byte_total_d   = '0;
        entries_seen_d = '0;
        walk_error_d   = rcp_pkg::StOk;
        match_count_d  = '0;
        first_match_d  = '0;
      end

      push_o = event_o.has_entry || event_o.has_status;
    end
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      header_pos_q   <= '0;
      type_shift_q   <= '0;
      name_shift_q   <= '0;
      size_shift_q   <= '0;
      payload_left_q <= '0;
      byte_total_q   <= '0;
      entries_seen_q <= '0;
      walk_error_q   <= rcp_pkg::StOk;
      match_count_q  <= '0;
      first_match_q  <= '0;
    end else begin
      in_payload_q   <= in_payload_d;
      header_pos_q   <= header_pos_d;
      type_shift_q   <= type_shift_d;
      name_shift_q   <= name_shift_d;
      size_shift_q   <= size_shift_d;
      payload_left_q <= payload_left_d;
      byte_total_q   <= byte_total_d;
      entries_seen_q <= entries_seen_d;
      walk_error_q   <= walk_error_d;
      match_count_q  <= match_count_d;
      first_match_q  <= first_match_d;
    end
  end

endmodule

// File: hdl/rcp_queue.sv
// ----------------------------------------------------------------------------
// Resource container parser event queue
// Small FIFO of record events between the front end and the back end.
// ----------------------------------------------------------------------------
module rcp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rcp_pkg::rcp_event_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output rcp_pkg::rcp_event_t head_o
);

  rcp_pkg::rcp_event_t              slots_q [rcp_pkg::QDepth];
  logic [rcp_pkg::QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [rcp_pkg::QCntW-1:0]        count_q;
  logic                             do_push, do_pop;

  assign full_o  = (count_q == rcp_pkg::QCntW'(rcp_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/rcp_back.sv
// ----------------------------------------------------------------------------
// Resource container parser back end
// Unpacks queued events into result transfers through an output register.
// ----------------------------------------------------------------------------
module rcp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  rcp_pkg::rcp_event_t q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rcp_pkg::rcp_out_t   out_data_o
);

  logic              out_valid_q, out_valid_d;
  rcp_pkg::rcp_out_t out_q, out_d;
  logic              entry_sent_q, entry_sent_d;
  logic              load;

  assign load        = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Pick the next record: entry first, then status of the same byte
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    entry_sent_d = entry_sent_q;
    q_pop_o      = 1'b0;
    if (load && q_valid_i) begin
      out_valid_d = 1'b1;
      if (q_head_i.has_entry && !entry_sent_q) begin
        out_d             = q_head_i.entry_rec;
        out_d.last_result = !q_head_i.has_status;
        if (q_head_i.has_status) begin
          entry_sent_d = 1'b1;
        end else begin
          q_pop_o = 1'b1;
        end
      end else begin
        out_d             = q_head_i.status_rec;
        out_d.last_result = 1'b1;
        entry_sent_d      = 1'b0;
        q_pop_o           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      entry_sent_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      entry_sent_q <= entry_sent_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Resource container parser unit testbench
// Streams container files through the parser. Files are a short directed
// sequence, then random files: clean walks, cut headers, cut payloads,
// noise, and one walk past the 64-entry limit. Every record coming out
// is compared field by field against an in-bench walk predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ClkPeriod      = 12;
  localparam int unsigned ResetCycles    = 7;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned EndCycles      = 20;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned ItemTarget     = 1750;
  localparam int unsigned ClosingFiles   = 2;
  localparam int unsigned LimitCycles    = 400000;
  localparam int unsigned MaxPrinted     = 100;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid;
  logic                        in_ready_o;
  rcp_pkg::rcp_in_t            in_data;
  logic                        out_valid_o;
  logic                        out_ready;
  rcp_pkg::rcp_out_t           out_data_o;
  logic                        cfg_valid;
  logic                        cfg_ready_o;
  logic [rcp_pkg::CfgIdxW-1:0] cfg_index;
  logic [31:0]                 cfg_data;

  resource_container_parser_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Predictor copy of the configuration
  logic [23:0] cfg_max_size;
  logic [31:0] cfg_find_type;

  // Predictor copy of the walk state
  logic                         skipping_payload;
  logic [3:0]                   hdr_byte_pos;
  logic [31:0]                  type_acc;
  logic [63:0]                  name_acc;
  logic [31:0]                  size_acc;
  logic [31:0]                  bytes_to_skip;
  logic [rcp_pkg::ByteCntW-1:0] file_bytes_seen;
  logic [6:0]                   entry_count;
  logic [2:0]                   latched_err;
  logic [1:0]                   type_hits;
  logic [5:0]                   first_hit_idx;

  rcp_pkg::rcp_out_t awaited_records[$];
  logic [7:0]        file_q[$];
  logic [2:0]        last_status_seen;
  int                error_count;
  int                items_sent;
  int                file_no;
  bit                idle_on;
  bit                long_hold_req;

  // Directed stimulus; a status code is typed in where it is obvious
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
    logic       code_known;
    logic [2:0] code;
  } directed_row_t;

  directed_row_t directed_rows [25] = '{
    // one-byte file right after reset
    '{8'hA5, 1'b1, 1'b1, rcp_pkg::StBadSize},
    // header: type 0, name all ones, size 0
    '{8'h00, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'h00, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'h00, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'h00, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'h00, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'h00, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'h00, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'h00, 1'b0, 1'b0, rcp_pkg::StOk},
    // second header cut after 8 bytes
    '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk},
    '{8'hFF, 1'b0, 1'b0, rcp_pkg::StOk}, '{8'hFF, 1'b1, 1'b1, rcp_pkg::StTruncHdr}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("FAIL resource_container_parser_unit");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic clear_walk_state();
    skipping_payload = 1'b0;
    hdr_byte_pos     = '0;
    type_acc         = '0;
    name_acc         = '0;
    size_acc         = '0;
    bytes_to_skip    = '0;
    file_bytes_seen  = '0;
    entry_count      = '0;
    latched_err      = rcp_pkg::StOk;
    type_hits        = '0;
    first_hit_idx    = '0;
  endtask

  // Entry fully walked: too-many latches once past the table limit
  task automatic close_entry();
    if (entry_count > rcp_pkg::MaxEntries && latched_err == rcp_pkg::StOk)
      latched_err = rcp_pkg::StTooMany;
  endtask

  // Advance the walk by one byte and queue the records it produces
  task automatic walk_container_byte(input rcp_pkg::rcp_in_t item);
    rcp_pkg::rcp_out_t entry_rec;
    rcp_pkg::rcp_out_t status_rec;
    logic              has_entry;
    logic [3:0]        pos;
    logic [2:0]        code;
    entry_rec  = '0;
    status_rec = '0;
    has_entry  = 1'b0;
    if (file_bytes_seen < rcp_pkg::ByteCap) file_bytes_seen = file_bytes_seen + 1'b1;

    if (skipping_payload) begin
      bytes_to_skip = bytes_to_skip - 1;
      if (bytes_to_skip == 0) begin
        skipping_payload = 1'b0;
        close_entry();
      end
    end else begin
      pos = hdr_byte_pos;
      if (pos < rcp_pkg::TypeEndPos) type_acc = {item.data_byte, type_acc[31:8]};
      else if (pos < rcp_pkg::NameEndPos) name_acc = {item.data_byte, name_acc[63:8]};
      else size_acc = {item.data_byte, size_acc[31:8]};
      hdr_byte_pos = pos + 4'd1;
      if (pos == rcp_pkg::LastPos) begin
        if (entry_count < rcp_pkg::MaxEntries) begin
          has_entry             = 1'b1;
          entry_rec.record_kind = rcp_pkg::KindEntry;
          entry_rec.entry_index = entry_count[5:0];
          entry_rec.entry_type  = type_acc;
          entry_rec.entry_name  = name_acc;
          entry_rec.payload_len = size_acc;
          entry_rec.data_offset = (file_bytes_seen > {1'b0, rcp_pkg::OffsetMax})
                                  ? rcp_pkg::OffsetMax : file_bytes_seen[23:0];
          if (type_acc == cfg_find_type) begin
            if (type_hits == 0) first_hit_idx = entry_count[5:0];
            if (type_hits < 2) type_hits = type_hits + 1'b1;
          end
        end
        if (entry_count <= rcp_pkg::MaxEntries) entry_count = entry_count + 1'b1;
        bytes_to_skip = size_acc;
        if (size_acc != 0) skipping_payload = 1'b1;
        else close_entry();
      end
    end

    if (has_entry) begin
      entry_rec.last_result = !item.end_of_file;
      awaited_records.push_back(entry_rec);
    end

    // End of file: size check first, then latched error, then truncation
    if (item.end_of_file) begin
      if (file_bytes_seen < rcp_pkg::MinFile || file_bytes_seen > {1'b0, cfg_max_size})
        code = rcp_pkg::StBadSize;
      else if (latched_err != rcp_pkg::StOk) code = latched_err;
      else if (!skipping_payload && hdr_byte_pos != 0) code = rcp_pkg::StTruncHdr;
      else if (skipping_payload) code = rcp_pkg::StTruncBody;
      else code = rcp_pkg::StOk;
      status_rec.record_kind = rcp_pkg::KindStatus;
      status_rec.status_code = code;
      if (code == rcp_pkg::StOk) begin
        status_rec.entry_total = entry_count;
        if (type_hits == 1) begin
          status_rec.match_found = 1'b1;
          status_rec.match_index = first_hit_idx;
        end
      end
      status_rec.last_result = 1'b1;
      awaited_records.push_back(status_rec);
      clear_walk_state();
    end
  endtask

  task automatic check_parser_record(input rcp_pkg::rcp_out_t got);
    rcp_pkg::rcp_out_t want;
    if (awaited_records.size() == 0) begin
      report_mismatch("record with none awaited", got.record_kind, 0);
    end else begin
      want = awaited_records.pop_front();
      if (got.record_kind !== want.record_kind)
        report_mismatch("record_kind", got.record_kind, want.record_kind);
      if (got.entry_index !== want.entry_index)
        report_mismatch("entry_index", got.entry_index, want.entry_index);
      if (got.entry_type !== want.entry_type)
        report_mismatch("entry_type", got.entry_type, want.entry_type);
      if (got.entry_name !== want.entry_name)
        report_mismatch("entry_name", got.entry_name, want.entry_name);
      if (got.payload_len !== want.payload_len)
        report_mismatch("payload_len", got.payload_len, want.payload_len);
      if (got.data_offset !== want.data_offset)
        report_mismatch("data_offset", got.data_offset, want.data_offset);
      if (got.status_code !== want.status_code)
        report_mismatch("status_code", got.status_code, want.status_code);
      if (got.entry_total !== want.entry_total)
        report_mismatch("entry_total", got.entry_total, want.entry_total);
      if (got.match_found !== want.match_found)
        report_mismatch("match_found", got.match_found, want.match_found);
      if (got.match_index !== want.match_index)
        report_mismatch("match_index", got.match_index, want.match_index);
      if (got.last_result !== want.last_result)
        report_mismatch("last_result", got.last_result, want.last_result);
    end
    if (got.record_kind == rcp_pkg::KindStatus) last_status_seen = got.status_code;
  endtask

  // Sample all three channels on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          rcp_pkg::CfgMaxFileSize: cfg_max_size = cfg_data[23:0];
          rcp_pkg::CfgFindType:    cfg_find_type = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready_o) walk_container_byte(in_data);
      if (out_valid_o && out_ready) check_parser_record(out_data_o);
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  // One byte transfer; valid stays up so back-to-back bytes need no gap
  task automatic push_byte(input logic [7:0] data_byte, input logic end_of_file);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: data_byte, end_of_file: end_of_file};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Hold input until every awaited record is out and the block has settled
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (awaited_records.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [23:0] max_size, input logic [31:0] find);
    logic [7:0] junk;
    junk = $urandom_range(0, 255);
    cfg_valid <= 1'b1;
    cfg_index <= rcp_pkg::CfgMaxFileSize;
    cfg_data  <= {junk, max_size};
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index <= rcp_pkg::CfgFindType;
    cfg_data  <= find;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_max_size();
    case ($urandom_range(0, 3))
      0:       return 24'(rcp_pkg::MinFile);
      1:       return rcp_pkg::OffsetMax;
      2:       return 24'($urandom_range(16, 64));
      default: return 24'($urandom_range(16, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [31:0] pick_find_type();
    case ($urandom_range(0, 2))
      0:       return 32'h0;
      1:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // Entry types lean toward the searched one so match counts vary
  function automatic logic [31:0] pick_type();
    case ($urandom_range(0, 4))
      0, 1:    return cfg_find_type;
      2:       return 32'h0;
      3:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_raw_bytes(input int unsigned n);
    repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_header(input logic [31:0] fourcc, input logic [31:0] len);
    for (int i = 0; i < 4; i++) file_q.push_back(fourcc[8*i +: 8]);
    add_raw_bytes(8);
    for (int i = 0; i < 4; i++) file_q.push_back(len[8*i +: 8]);
  endtask

  // Mostly well-formed walks, some cut short, some noise
  task automatic build_small_file();
    int unsigned shape;
    int unsigned n;
    logic [31:0] len;
    file_q.delete();
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      add_raw_bytes($urandom_range(1, 20));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        len = $urandom_range(0, 6);
        add_header(pick_type(), len);
        add_raw_bytes(len);
      end
      if (shape <= 2) begin
        // partial header at the end
        add_raw_bytes($urandom_range(1, 15));
      end else if (shape <= 4) begin
        // payload cut short, possibly right at the header end
        len = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(1, 12));
        if (len == 0) len = 1;
        add_header(pick_type(), len);
        add_raw_bytes($urandom_range(0, (len > 12) ? 12 : len - 1));
      end
    end
  endtask

  // Walk around the table limit; mostly empty payloads to keep it short
  task automatic build_full_file(input int unsigned n_entries, input bit cut_tail);
    logic [31:0] len;
    file_q.delete();
    repeat (n_entries) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
      add_header(pick_type(), len);
      add_raw_bytes(len);
    end
    if (cut_tail) add_raw_bytes($urandom_range(1, 20));
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++)
      push_byte(file_q[i], i == file_q.size() - 1);
  endtask

  // Main stimulus
  initial begin
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = rcp_pkg::CfgMaxFileSize;
    cfg_data      = '0;
    cfg_max_size  = rcp_pkg::OffsetMax;
    cfg_find_type = '0;
    clear_walk_state();
    last_status_seen = rcp_pkg::StOk;
    error_count   = 0;
    items_sent    = 0;
    file_no       = 0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table under reset settings
    foreach (directed_rows[r]) begin
      push_byte(directed_rows[r].data_byte, directed_rows[r].end_of_file);
      if (directed_rows[r].code_known) begin
        wait_results_drained();
        if (last_status_seen !== directed_rows[r].code)
          report_mismatch("directed status_code", last_status_seen, directed_rows[r].code);
      end
    end
    wait_results_drained();
    write_settings(24'(rcp_pkg::MinFile), 32'hFFFFFFFF);

    // Random files, settings changed every few files
    while (items_sent < ItemTarget) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (file_no == 4) begin
        // one walk past the table limit while the result side holds off
        wait_results_drained();
        write_settings(rcp_pkg::OffsetMax, pick_find_type());
        idle_on = 1'b0;
        long_hold_req = 1'b1;
        build_full_file(rcp_pkg::MaxEntries + 1 + $urandom_range(0, 1),
                        1'($urandom_range(0, 1)));
      end else begin
        if (file_no % 3 == 0 && file_no > 0) begin
          wait_results_drained();
          write_settings(pick_max_size(), pick_find_type());
        end
        build_small_file();
      end
      send_file();
      file_no++;
    end

    // Closing stretch without idling
    idle_on = 1'b0;
    repeat (ClosingFiles) begin
      build_small_file();
      send_file();
    end
    in_valid <= 1'b0;

    while (awaited_records.size() != 0) @(posedge clk_i);
    repeat (EndCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS resource_container_parser_unit");
    end else begin
      $display("FAIL resource_container_parser_unit");
    end
    $finish;
  end

endmodule
